// ----- design/stl_pkg.sv -----
// Shared types and constants for the s-expression token lexer.
// Used by stl_ctrl, stl_dp and scheme_token_lexer; depends on nothing else.

package stl_pkg;

    // Longest symbol that is buffered before a too-long error is raised.
    localparam int SYM_MAX = 32;
    localparam int SYM_AW  = (SYM_MAX > 1) ? $clog2(SYM_MAX) : 1;
    localparam int SYM_LW  = $clog2(SYM_MAX + 1);

    // Constant value width and the width of the times-ten-plus-digit product.
    localparam int VAL_W  = 64;
    localparam int PROD_W = VAL_W + 4;

    // Packed port widths.
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = VAL_W + 8;
    localparam int M_USER_W = 4;

    // Token kinds as they appear on the result channel.
    typedef enum logic [2:0] {
        KIND_OPEN  = 3'd0,
        KIND_CLOSE = 3'd1,
        KIND_QUOTE = 3'd2,
        KIND_DOT   = 3'd3,
        KIND_CONST = 3'd4,
        KIND_SYM   = 3'd5,
        KIND_END   = 3'd6,
        KIND_ERROR = 3'd7
    } kind_t;

    // Lexer mode between characters.
    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_SIGN  = 2'd1,
        MODE_CONST = 2'd2,
        MODE_SYM   = 2'd3
    } mode_t;

    // Which result the datapath loads into its output register.
    typedef enum logic [2:0] {
        EM_NONE  = 3'd0,
        EM_FLUSH = 3'd1,
        EM_SYMCH = 3'd2,
        EM_TAIL  = 3'd3,
        EM_ERROR = 3'd4
    } emit_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      take;        // latch the accepted input transaction
        logic      sign_digit;  // first digit after a sign: enter constant mode
        logic      mul;         // form accumulator * 10 + digit
        logic      acc_load;    // commit the product to the accumulator
        logic      sym_append;  // append the character to the symbol store
        logic      drain_rd;    // read the next buffered symbol character
        emit_sel_t emit;        // result to load into the output register
        logic      emit_last;   // final result caused by this input
        logic      tail;        // apply the start-of-token rules to the character
        logic      clear;       // return to idle
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic  eoi;          // latched input is an end-of-input marker
        mode_t mode;
        logic  digit;        // latched character is a decimal digit
        logic  sym_cont;     // latched character may continue a symbol
        logic  sym_full;     // symbol store holds the maximum length
        logic  tail_emits;   // the tail step produces a result
        logic  ovf;          // product exceeds the signed range
        logic  drain_final;  // read index is on the last symbol character
        logic  out_free;     // output register can take a result this cycle
    } dp_stat_t;

endpackage

// ----- design/stl_dp.sv -----
// Datapath of the token lexer: input latch, character classes, constant
// accumulator, symbol store and the output register. Depends on stl_pkg.

module stl_dp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [7:0]                    in_ch,
    input  logic                          in_eoi,
    input  stl_pkg::dp_cmd_t              cmd,
    output stl_pkg::dp_stat_t             stat,
    input  logic                          m_tready,
    output logic                          m_tvalid,
    output logic [stl_pkg::M_DATA_W-1:0]  m_tdata,
    output logic [stl_pkg::M_USER_W-1:0]  m_tuser,
    output logic                          m_tlast
);
    import stl_pkg::*;

    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_QUOTE = 8'h27;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Latched input transaction.
    logic [7:0] ch_reg;
    logic       eoi_reg;

    // Token state.
    mode_t              mode_reg,   mode_next;
    logic               neg_reg,    neg_next;
    logic [VAL_W-1:0]   acc_reg,    acc_next;
    logic [SYM_LW-1:0]  len_reg,    len_next;
    logic [SYM_LW-1:0]  rd_idx_reg, rd_idx_next;
    logic [PROD_W-1:0]  prod_reg;
    logic [7:0]         rd_data_reg;

    // Symbol store, written on one port and read on another.
    logic [7:0]         sym_mem [SYM_MAX];
    logic               wr_en;
    logic [SYM_AW-1:0]  wr_addr;

    // Output register.
    logic               out_valid_reg;
    logic [VAL_W-1:0]   out_value_reg;
    logic [7:0]         out_char_reg;
    kind_t              out_kind_reg;
    logic               out_slast_reg;
    logic               out_last_reg;

    // Character classes of the latched character.
    logic               c_digit, c_alpha, c_other, c_space, c_sign, c_punct;
    logic               c_symstart, c_cont, c_illegal;
    logic [3:0]         dig;
    logic [VAL_W-1:0]   limit;

    // Result fields selected for the output register.
    kind_t              em_kind;
    logic [VAL_W-1:0]   em_value;
    logic [7:0]         em_char;
    logic               em_slast;

    // Latch the input transaction.
    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            ch_reg  <= in_ch;
            eoi_reg <= in_eoi;
        end
    end

    // Classify the latched character.
    always_comb begin
        c_digit    = (ch_reg >= 8'h30) && (ch_reg <= 8'h39);
        c_alpha    = ((ch_reg >= 8'h61) && (ch_reg <= 8'h7A)) ||
                     ((ch_reg >= 8'h41) && (ch_reg <= 8'h5A));
        c_other    = (ch_reg == CH_LT) || (ch_reg == CH_EQ) || (ch_reg == CH_GT) ||
                     (ch_reg == CH_STAR) || (ch_reg == CH_HASH) || (ch_reg == CH_SLASH);
        c_space    = (ch_reg == CH_SPACE) || ((ch_reg >= 8'd9) && (ch_reg <= 8'd13));
        c_sign     = (ch_reg == CH_PLUS) || (ch_reg == CH_MINUS);
        c_punct    = (ch_reg == CH_OPEN) || (ch_reg == CH_CLOSE) ||
                     (ch_reg == CH_QUOTE) || (ch_reg == CH_DOT);
        c_symstart = c_alpha || c_other;
        c_cont     = c_symstart || c_digit || (ch_reg == CH_QMARK) ||
                     (ch_reg == CH_BANG) || (ch_reg == CH_MINUS);
        c_illegal  = !(c_space || c_punct || c_digit || c_symstart || c_sign);
        dig        = ch_reg[3:0];
        limit      = neg_reg ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
    end

    // Status towards the controller.
    always_comb begin
        stat.eoi         = eoi_reg;
        stat.mode        = mode_reg;
        stat.digit       = c_digit;
        stat.sym_cont    = c_cont;
        stat.sym_full    = (len_reg == SYM_LW'(SYM_MAX));
        stat.tail_emits  = eoi_reg || c_punct || c_illegal;
        stat.ovf         = (prod_reg > PROD_W'(limit));
        stat.drain_final = ((rd_idx_reg + SYM_LW'(1)) == len_reg);
        stat.out_free    = !out_valid_reg || m_tready;
    end

    // Next token state. Clearing comes first so that the start rules can
    // override it in the same cycle.
    always_comb begin
        mode_next   = mode_reg;
        neg_next    = neg_reg;
        acc_next    = acc_reg;
        len_next    = len_reg;
        rd_idx_next = rd_idx_reg;
        wr_en       = 1'b0;
        wr_addr     = len_reg[SYM_AW-1:0];

        if (cmd.clear) begin
            mode_next   = MODE_IDLE;
            neg_next    = 1'b0;
            acc_next    = '0;
            len_next    = '0;
            rd_idx_next = '0;
        end

        if (cmd.tail && !eoi_reg) begin
            if (c_digit) begin
                mode_next = MODE_CONST;
                acc_next  = VAL_W'(dig);
            end else if (c_symstart) begin
                mode_next = MODE_SYM;
                len_next  = SYM_LW'(1);
                wr_en     = 1'b1;
                wr_addr   = '0;
            end else if (c_sign) begin
                mode_next = MODE_SIGN;
                neg_next  = (ch_reg == CH_MINUS);
            end
        end

        if (cmd.sign_digit) begin
            mode_next = MODE_CONST;
            acc_next  = VAL_W'(dig);
        end

        if (cmd.acc_load) begin
            acc_next = prod_reg[VAL_W-1:0];
        end

        if (cmd.sym_append) begin
            wr_en    = 1'b1;
            len_next = len_reg + SYM_LW'(1);
        end

        if (cmd.emit == EM_SYMCH) begin
            rd_idx_next = rd_idx_reg + SYM_LW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_IDLE;
            neg_reg    <= 1'b0;
            acc_reg    <= '0;
            len_reg    <= '0;
            rd_idx_reg <= '0;
        end else begin
            mode_reg   <= mode_next;
            neg_reg    <= neg_next;
            acc_reg    <= acc_next;
            len_reg    <= len_next;
            rd_idx_reg <= rd_idx_next;
        end
    end

    // Times ten plus digit, as two shifted copies and the digit.
    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            prod_reg <= (PROD_W'(acc_reg) << 3) + (PROD_W'(acc_reg) << 1) + PROD_W'(dig);
        end
    end

    // Symbol store: write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            sym_mem[wr_addr] <= ch_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.drain_rd) begin
            rd_data_reg <= sym_mem[rd_idx_reg[SYM_AW-1:0]];
        end
    end

    // Select the fields of the result being emitted.
    always_comb begin
        em_kind  = KIND_ERROR;
        em_value = '0;
        em_char  = '0;
        em_slast = 1'b0;
        unique case (cmd.emit)
            EM_FLUSH: begin
                if (mode_reg == MODE_SIGN) begin
                    em_kind  = KIND_SYM;
                    em_char  = neg_reg ? CH_MINUS : CH_PLUS;
                    em_slast = 1'b1;
                end else begin
                    em_kind  = KIND_CONST;
                    em_value = neg_reg ? (VAL_W'(0) - acc_reg) : acc_reg;
                end
            end
            EM_SYMCH: begin
                em_kind  = KIND_SYM;
                em_char  = rd_data_reg;
                em_slast = stat.drain_final;
            end
            EM_TAIL: begin
                if (eoi_reg) begin
                    em_kind = KIND_END;
                end else if (ch_reg == CH_OPEN) begin
                    em_kind = KIND_OPEN;
                end else if (ch_reg == CH_CLOSE) begin
                    em_kind = KIND_CLOSE;
                end else if (ch_reg == CH_QUOTE) begin
                    em_kind = KIND_QUOTE;
                end else if (ch_reg == CH_DOT) begin
                    em_kind = KIND_DOT;
                end else begin
                    em_kind = KIND_ERROR;
                end
            end
            EM_ERROR: begin
                em_kind = KIND_ERROR;
            end
            default: begin
                em_kind = KIND_ERROR;
            end
        endcase
    end

    // Output register: loaded on an emit, emptied when the transaction is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit != EM_NONE) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit != EM_NONE) begin
            out_kind_reg  <= em_kind;
            out_value_reg <= em_value;
            out_char_reg  <= em_char;
            out_slast_reg <= em_slast;
            out_last_reg  <= cmd.emit_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_char_reg, out_value_reg};
    assign m_tuser  = {out_slast_reg, out_kind_reg};
    assign m_tlast  = out_last_reg;

endmodule

// ----- design/stl_ctrl.sv -----
// Controller of the token lexer: a one-hot state machine that sequences
// each character through the datapath. Depends on stl_pkg.

module stl_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  stl_pkg::dp_stat_t stat,
    output stl_pkg::dp_cmd_t  cmd
);
    import stl_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_DECIDE   = 9'b000000010,
        S_MUL      = 9'b000000100,
        S_CHK      = 9'b000001000,
        S_FLUSH    = 9'b000010000,
        S_DRAIN_RD = 9'b000100000,
        S_DRAIN_EM = 9'b001000000,
        S_TAIL     = 9'b010000000,
        S_ERR      = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    // No input transaction is taken while reset is held.
    assign s_tready = aresetn && (state_reg == S_IDLE);

    // Next state and datapath commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.emit   = EM_NONE;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.take   = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (stat.eoi) begin
                    if (stat.mode == MODE_IDLE) begin
                        state_next = S_TAIL;
                    end else if (stat.mode == MODE_SYM) begin
                        state_next = S_DRAIN_RD;
                    end else begin
                        state_next = S_FLUSH;
                    end
                end else if ((stat.mode == MODE_SIGN) && stat.digit) begin
                    cmd.sign_digit = 1'b1;
                    state_next     = S_IDLE;
                end else if ((stat.mode == MODE_CONST) && stat.digit) begin
                    state_next = S_MUL;
                end else if ((stat.mode == MODE_SYM) && stat.sym_cont) begin
                    if (stat.sym_full) begin
                        state_next = S_ERR;
                    end else begin
                        cmd.sym_append = 1'b1;
                        state_next     = S_IDLE;
                    end
                end else if (stat.mode == MODE_SYM) begin
                    state_next = S_DRAIN_RD;
                end else if (stat.mode == MODE_IDLE) begin
                    state_next = S_TAIL;
                end else begin
                    state_next = S_FLUSH;
                end
            end
            S_MUL: begin
                cmd.mul    = 1'b1;
                state_next = S_CHK;
            end
            S_CHK: begin
                if (stat.ovf) begin
                    state_next = S_ERR;
                end else begin
                    cmd.acc_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_FLUSH: begin
                if (stat.out_free) begin
                    cmd.emit      = EM_FLUSH;
                    cmd.emit_last = !stat.tail_emits;
                    state_next    = S_TAIL;
                end
            end
            S_DRAIN_RD: begin
                cmd.drain_rd = 1'b1;
                state_next   = S_DRAIN_EM;
            end
            S_DRAIN_EM: begin
                if (stat.out_free) begin
                    cmd.emit      = EM_SYMCH;
                    cmd.emit_last = stat.drain_final && !stat.tail_emits;
                    state_next    = stat.drain_final ? S_TAIL : S_DRAIN_RD;
                end
            end
            S_TAIL: begin
                if (!stat.tail_emits || stat.out_free) begin
                    cmd.tail      = 1'b1;
                    cmd.clear     = 1'b1;
                    cmd.emit      = stat.tail_emits ? EM_TAIL : EM_NONE;
                    cmd.emit_last = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_ERR: begin
                if (stat.out_free) begin
                    cmd.emit      = EM_ERROR;
                    cmd.emit_last = 1'b1;
                    cmd.clear     = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- design/scheme_token_lexer.sv -----
// Top level of the s-expression token lexer: joins the controller and the
// datapath. Depends on stl_pkg, stl_ctrl and stl_dp.
//
// Channel  Direction  Data                              User
// s_       in         [7:0] ch                          [0] end_of_input
// m_       out        [63:0] value, [71:64] sym_char    [2:0] kind, [3] sym_last
//                     tlast: final result of one input transaction
//
// A character that only extends a token is accepted and then decided;
// a digit of a constant then passes the times-ten-plus-digit and range
// check states. Each buffered symbol character is read from the symbol
// store, a registered read, and then emitted. A flushed token, the closing
// token and an error are each loaded once the output register is free.
// Reset is synchronous and returns the lexer to idle with no result pending.
// A stalled result channel holds the controller; the next input is accepted
// once the last result of the previous one sits in the output register.

module scheme_token_lexer (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [stl_pkg::S_DATA_W-1:0]  s_tdata,   // [7:0] ch
    input  logic                          s_tuser,   // [0] end_of_input
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [stl_pkg::M_DATA_W-1:0]  m_tdata,   // [63:0] value, [71:64] sym_char
    output logic [stl_pkg::M_USER_W-1:0]  m_tuser,   // [2:0] kind, [3] sym_last
    output logic                          m_tlast
);
    import stl_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Sequencing of each input transaction.
    stl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Token state, symbol store and output register.
    stl_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_ch    (s_tdata[7:0]),
        .in_eoi   (s_tuser),
        .cmd      (cmd),
        .stat     (stat),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ----- bench/scheme_token_lexer_tb.sv -----
// Self-checking testbench for the s-expression token lexer: character stream in, tokens out.
// A scoreboard class predicts each token from its own copy of the lexer state.
// Depends on stl_pkg and the scheme_token_lexer design only.

module scheme_token_lexer_tb;

    import stl_pkg::*;

    localparam int DIRECTED_ITEMS = 25;
    localparam int RANDOM_ITEMS   = 385;
    localparam int DRAIN_CYCLES   = 100;
    localparam int CYCLE_LIMIT    = 2000000;
    localparam int MAX_PRINTED    = 100;

    // One expected token, split into the fields of a result transaction.
    typedef struct {
        kind_t       kind;
        logic [63:0] value;
        logic [7:0]  sym_char;
        logic        sym_last;
        logic        last;
    } token_t;

    // One character transaction for the input channel.
    typedef struct {
        logic [7:0] ch;
        logic       eoi;
    } stim_t;

    // Predicts the token stream and compares it with the result channel.
    class token_scoreboard;
        token_t      expected_tokens[$];
        token_t      fresh[$];
        mode_t       lex_mode;
        logic        minus;
        logic [63:0] magnitude;
        logic [7:0]  sym_buf[SYM_MAX];
        int          sym_len;
        int          mismatches;

        function new();
            mismatches = 0;
            go_idle();
        endfunction

        function int pending();
            return expected_tokens.size();
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            if (mismatches <= MAX_PRINTED)
                $display("MISMATCH: %s", msg);
        endtask

        function bit is_digit(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function bit is_alpha(logic [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        endfunction

        function bit is_other(logic [7:0] c);
            return c == "<" || c == "=" || c == ">" || c == "*" || c == "#" || c == "/";
        endfunction

        function bit is_space(logic [7:0] c);
            return c == " " || (c >= 8'd9 && c <= 8'd13);
        endfunction

        function bit sym_continues(logic [7:0] c);
            return is_alpha(c) || is_digit(c) || is_other(c) || c == "?" || c == "!" || c == "-";
        endfunction

        function void go_idle();
            lex_mode  = MODE_IDLE;
            minus     = 1'b0;
            magnitude = '0;
            sym_len   = 0;
        endfunction

        function void emit(kind_t k, logic [63:0] v, logic [7:0] c, logic sl);
            token_t t;
            t.kind     = k;
            t.value    = v;
            t.sym_char = c;
            t.sym_last = sl;
            t.last     = 1'b0;
            fresh.push_back(t);
        endfunction

        // Emits whatever token is pending and returns to idle.
        function void flush_token();
            case (lex_mode)
                MODE_SIGN:  emit(KIND_SYM, '0, minus ? "-" : "+", 1'b1);
                MODE_CONST: emit(KIND_CONST, minus ? 64'd0 - magnitude : magnitude, '0, 1'b0);
                MODE_SYM: begin
                    for (int i = 0; i < sym_len; i++)
                        emit(KIND_SYM, '0, sym_buf[i], i == sym_len - 1);
                end
                default: ;
            endcase
            go_idle();
        endfunction

        // Start-of-token rules for a character seen while idle.
        function void open_token(logic [7:0] c);
            if (is_space(c)) begin
                return;
            end else if (c == "(") begin
                emit(KIND_OPEN, '0, '0, 1'b0);
            end else if (c == ")") begin
                emit(KIND_CLOSE, '0, '0, 1'b0);
            end else if (c == "'") begin
                emit(KIND_QUOTE, '0, '0, 1'b0);
            end else if (c == ".") begin
                emit(KIND_DOT, '0, '0, 1'b0);
            end else if (is_digit(c)) begin
                lex_mode  = MODE_CONST;
                minus     = 1'b0;
                magnitude = 64'(c - "0");
            end else if (is_alpha(c) || is_other(c)) begin
                lex_mode   = MODE_SYM;
                sym_buf[0] = c;
                sym_len    = 1;
            end else if (c == "+" || c == "-") begin
                lex_mode = MODE_SIGN;
                minus    = (c == "-");
            end else begin
                emit(KIND_ERROR, '0, '0, 1'b0);
            end
        endfunction

        // Notes one accepted input transaction and queues the tokens it causes.
        function void note_transaction(logic [7:0] c, logic eoi);
            logic [63:0] digit_val;
            logic [63:0] ceiling;
            fresh.delete();
            digit_val = 64'(c - "0");
            if (eoi) begin
                flush_token();
                emit(KIND_END, '0, '0, 1'b0);
            end else begin
                case (lex_mode)
                    MODE_SIGN: begin
                        if (is_digit(c)) begin
                            lex_mode  = MODE_CONST;
                            magnitude = digit_val;
                        end else begin
                            flush_token();
                            open_token(c);
                        end
                    end
                    MODE_CONST: begin
                        if (is_digit(c)) begin
                            // A negative constant may reach one beyond the positive maximum.
                            ceiling = minus ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
                            if (magnitude > (ceiling - digit_val) / 64'd10) begin
                                emit(KIND_ERROR, '0, '0, 1'b0);
                                go_idle();
                            end else begin
                                magnitude = magnitude * 64'd10 + digit_val;
                            end
                        end else begin
                            flush_token();
                            open_token(c);
                        end
                    end
                    MODE_SYM: begin
                        if (sym_continues(c)) begin
                            if (sym_len >= SYM_MAX) begin
                                emit(KIND_ERROR, '0, '0, 1'b0);
                                go_idle();
                            end else begin
                                sym_buf[sym_len] = c;
                                sym_len++;
                            end
                        end else begin
                            flush_token();
                            open_token(c);
                        end
                    end
                    default: open_token(c);
                endcase
            end
            if (fresh.size() > 0)
                fresh[fresh.size() - 1].last = 1'b1;
            foreach (fresh[i])
                expected_tokens.push_back(fresh[i]);
        endfunction

        // Compares one result transaction with the oldest expected token.
        task check_transaction(logic [M_DATA_W-1:0] data, logic [M_USER_W-1:0] user,
                               logic tlast);
            token_t want;
            if (expected_tokens.size() == 0) begin
                report_mismatch($sformatf("result with no token expected: kind %0d value %0d",
                                          user[2:0], $signed(data[63:0])));
                return;
            end
            want = expected_tokens.pop_front();
            if (user[2:0] !== want.kind)
                report_mismatch($sformatf("kind %0d, expected %0d", user[2:0], want.kind));
            if (data[63:0] !== want.value)
                report_mismatch($sformatf("value %0d, expected %0d",
                                          $signed(data[63:0]), $signed(want.value)));
            if (data[71:64] !== want.sym_char)
                report_mismatch($sformatf("sym_char 0x%02h, expected 0x%02h",
                                          data[71:64], want.sym_char));
            if (user[3] !== want.sym_last)
                report_mismatch($sformatf("sym_last %b, expected %b", user[3], want.sym_last));
            if (tlast !== want.last)
                report_mismatch($sformatf("tlast %b, expected %b", tlast, want.last));
        endtask
    endclass

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                s_tuser  = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic [M_USER_W-1:0] m_tuser;
    logic                m_tlast;

    token_scoreboard sb;
    stim_t           burst[$];
    logic            quiet = 1'b0;
    int              items_sent = 0;
    int              rx_stall = 0;
    int              cycle_count = 0;

    scheme_token_lexer u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #1 aclk = ~aclk;

    // Result side: check each transaction, then stall for a random number of cycles.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_stall = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                sb.check_transaction(m_tdata, m_tuser, m_tlast);
                rx_stall = quiet ? 0 : $urandom_range(0, 10);
            end
            if (rx_stall > 0) begin
                rx_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog on the total run length.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // Drives one input transaction after a random gap and waits for acceptance.
    task send_item(input logic [7:0] c, input logic eoi);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tuser  <= eoi;
        do @(posedge aclk); while (!s_tready);
        sb.note_transaction(c, eoi);
        items_sent++;
    endtask

    task send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], 1'b0);
    endtask

    // Holds the input channel low until every expected token has arrived.
    task hold_until_drained();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (sb.pending() != 0);
        @(posedge aclk);
    endtask

    task push_char(input logic [7:0] c);
        stim_t s;
        s.ch  = c;
        s.eoi = 1'b0;
        burst.push_back(s);
    endtask

    task push_end();
        stim_t s;
        s.ch  = 8'($urandom_range(0, 255));
        s.eoi = 1'b1;
        burst.push_back(s);
    endtask

    function logic [7:0] pick_space();
        int k;
        k = $urandom_range(0, 5);
        return (k == 0) ? " " : 8'(8 + k);
    endfunction

    function logic [7:0] pick_punct();
        string p;
        p = "()'.";
        return p[$urandom_range(0, 3)];
    endfunction

    function logic [7:0] pick_sym_start();
        string o;
        o = "<=>*#/";
        case ($urandom_range(0, 2))
            0:       return 8'("a" + $urandom_range(0, 25));
            1:       return 8'("A" + $urandom_range(0, 25));
            default: return o[$urandom_range(0, 5)];
        endcase
    endfunction

    function logic [7:0] pick_sym_cont();
        string x;
        x = "?!-";
        case ($urandom_range(0, 3))
            0:       return 8'("0" + $urandom_range(0, 9));
            1:       return x[$urandom_range(0, 2)];
            default: return pick_sym_start();
        endcase
    endfunction

    // A sign character, or zero for none.
    function logic [7:0] pick_sign();
        case ($urandom_range(0, 2))
            0:       return 8'd0;
            1:       return "+";
            default: return "-";
        endcase
    endfunction

    // A delimiter, an end of input or a random byte, or nothing so the next sequence runs on.
    task push_delimiter();
        case ($urandom_range(0, 9))
            0, 1, 2: push_char(pick_space());
            3, 4, 5: push_char(pick_punct());
            6:       push_end();
            7:       push_char(8'($urandom_range(0, 255)));
            default: ;
        endcase
    endtask

    task push_decimal(input logic [63:0] mag);
        logic [7:0] digs[$];
        do begin
            digs.push_front(8'("0" + 8'(mag % 64'd10)));
            mag = mag / 64'd10;
        end while (mag != 0);
        foreach (digs[i])
            push_char(digs[i]);
    endtask

    task add_constant();
        logic [7:0] sg;
        int         n;
        sg = pick_sign();
        if (sg != 8'd0)
            push_char(sg);
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) push_char("0");
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 18) : $urandom_range(1, 6);
        repeat (n) push_char(8'("0" + $urandom_range(0, 9)));
    endtask

    // Constants at the edge of the signed 64-bit range: offset 0 is the positive maximum.
    task add_boundary(input logic [7:0] sg, input int offset);
        if (sg != 8'd0)
            push_char(sg);
        push_decimal(64'h7FFF_FFFF_FFFF_FFFF + 64'(offset));
    endtask

    task add_symbol(input int len);
        push_char(pick_sym_start());
        repeat (len - 1) push_char(pick_sym_cont());
    endtask

    task build_sequence();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 22) begin
            add_constant();
        end else if (pick < 28) begin
            add_boundary(pick_sign(), $urandom_range(0, 2));
        end else if (pick < 32) begin
            // Far too many digits for any 64-bit constant.
            push_char(8'("1" + $urandom_range(0, 8)));
            repeat ($urandom_range(19, 21)) push_char(8'("0" + $urandom_range(0, 9)));
        end else if (pick < 56) begin
            add_symbol($urandom_range(1, 8));
        end else if (pick < 62) begin
            add_symbol($urandom_range(30, 35));
        end else if (pick < 72) begin
            push_char(pick_punct());
        end else if (pick < 78) begin
            push_char(pick_space());
        end else if (pick < 86) begin
            // A sign, then a delimiter, a symbol start or another sign.
            push_char($urandom_range(0, 1) ? "+" : "-");
            case ($urandom_range(0, 2))
                0:       push_delimiter();
                1:       push_char(pick_sym_start());
                default: push_char($urandom_range(0, 1) ? "+" : "-");
            endcase
            return;
        end else if (pick < 94) begin
            push_char(8'($urandom_range(0, 255)));
            return;
        end else begin
            push_end();
            return;
        end
        if (pick < 62)
            push_delimiter();
    endtask

    // Stimulus: directed opening, then random token sequences.
    initial begin
        stim_t s;
        int    seq_count;
        int    next_toggle;
        bit    drained_once;
        sb           = new();
        seq_count    = 0;
        next_toggle  = 0;
        drained_once = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Extreme bytes, punctuation, whitespace, lone signs, a signed constant,
        // leading zeros, a symbol ended by a bracket, and end of input twice.
        send_item(8'd0, 1'b0);
        send_item(8'd255, 1'b0);
        send_text("()'.");
        send_item(8'd9, 1'b0);
        send_item(8'd13, 1'b0);
        send_text("- +(-7)007'a?-(");
        send_item(8'($urandom_range(0, 255)), 1'b1);
        send_item(8'($urandom_range(0, 255)), 1'b1);

        while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
            if (items_sent >= next_toggle) begin
                quiet <= ($urandom_range(0, 3) == 0);
                next_toggle += 30;
            end
            if (!drained_once && items_sent >= DIRECTED_ITEMS + RANDOM_ITEMS / 2) begin
                hold_until_drained();
                drained_once = 1'b1;
            end
            // The first few sequences pin the range limits and the symbol length limit.
            case (seq_count)
                0:       add_boundary(8'd0, 0);
                1:       add_boundary("-", 1);
                2:       add_boundary("+", 1);
                3:       add_boundary("-", 2);
                4:       add_symbol(SYM_MAX);
                5:       add_symbol(SYM_MAX + 1);
                default: build_sequence();
            endcase
            if (seq_count < 6)
                push_char(pick_space());
            seq_count++;
            while (burst.size() > 0) begin
                s = burst.pop_front();
                send_item(s.ch, s.eoi);
            end
        end

        // Let the lexer finish, then give it time for anything unexpected.
        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d expected tokens never arrived", sb.pending()));
        if (sb.mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
